>>> rtl/core/hsl2rgb_pkg.sv
// ============================================================================
// hsl2rgb_pkg
// Shared types and constants for the HSL to RGB color converter.
// ============================================================================
package hsl2rgb_pkg;

  // Default number of fraction bits in the fixed-point inputs
  localparam int DEFAULT_FRACTION_BITS = 16;

  // Fixed widths of the interface fields
  localparam int HUE_W     = 16;
  localparam int SL_W      = 17;
  localparam int CHANNEL_W = 8;
  localparam int PACKED_W  = 3 * CHANNEL_W;

  // Hue sextant, named by the color ramp it covers
  typedef enum logic [2:0] {
    SEXT_R_TO_Y = 3'd0,
    SEXT_Y_TO_G = 3'd1,
    SEXT_G_TO_C = 3'd2,
    SEXT_C_TO_B = 3'd3,
    SEXT_B_TO_M = 3'd4,
    SEXT_M_TO_R = 3'd5
  } sextant_t;

endpackage

>>> rtl/core/hsl_to_rgb_converter.sv
// ============================================================================
// hsl_to_rgb_converter
// Pipelined HSL to RGB conversion: one hue/saturation/lightness transaction
// in, 8-bit red, green, blue and the packed 24-bit color out.
// ============================================================================
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------
//  request   | hue, saturation, lightness              | start, busy
//  result    | red, green, blue, packed_color          | done (1-cycle strobe)
//
//  One transaction per clock, every clock: busy is never raised.
//  Work passes through the registered stages limit -> l*s product -> peak ->
//  floor -> span -> span*fraction multiply -> ramp select -> channel scale, to done.
//  rst (synchronous) clears the stage valid bits; in-flight work is dropped.
//  The receiver cannot stall, so the pipeline never holds.
//
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [HUE_W-1:0]      hue,
  input  logic [SL_W-1:0]       saturation,
  input  logic [SL_W-1:0]       lightness,
  output logic                  done,
  output logic [CHANNEL_W-1:0]  red,
  output logic [CHANNEL_W-1:0]  green,
  output logic [CHANNEL_W-1:0]  blue,
  output logic [PACKED_W-1:0]   packed_color
);

  localparam int FB      = FRACTION_BITS;
  localparam int LW      = FB + 1;                       // value width, holds 1.0
  localparam int XW      = (SL_W > LW) ? SL_W : LW;      // compare width for limits
  localparam int H6W     = (HUE_W + 3 > FB) ? HUE_W + 3 : FB + 1;
  localparam int SXW     = H6W - FB;
  localparam int LATENCY = 8;

  localparam logic [LW-1:0] ONE  = {1'b1, {FB{1'b0}}};
  localparam logic [LW-1:0] HALF = ONE >> 1;

  // channel scale: (x * 255) >> FB, x never above 1.0
  function automatic logic [CHANNEL_W-1:0] to_chan(input logic [LW-1:0] x);
    logic [LW+7:0] p;
    p = {x, 8'b0} - (LW+8)'(x);
    return CHANNEL_W'(p >> FB);
  endfunction

  // stage valid bits
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  assign busy = 1'b0;
  assign done = vld[LATENCY-1];

  // --------------------------------------------------------------------------
  // Stage 1: limit saturation and lightness, scale hue by six
  // --------------------------------------------------------------------------
  logic [XW-1:0]  sat_x, lit_x;
  logic [H6W-1:0] hue6;
  logic [SXW-1:0] sext_raw;
  logic [LW-1:0]  s1_sat, s1_lit;
  logic [FB-1:0]  s1_fract;
  sextant_t       s1_sext;
  logic           s1_grey;

  assign sat_x    = XW'(saturation);
  assign lit_x    = XW'(lightness);
  assign hue6     = (H6W'(hue) << 2) + (H6W'(hue) << 1);
  assign sext_raw = hue6[H6W-1:FB];

  always_ff @(posedge clk) begin
    s1_sat   <= (sat_x > XW'(ONE)) ? ONE : LW'(sat_x);
    s1_lit   <= (lit_x > XW'(ONE)) ? ONE : LW'(lit_x);
    s1_fract <= hue6[FB-1:0];
    s1_sext  <= sextant_t'(3'(32'(sext_raw)));
    s1_grey  <= (32'(sext_raw) > 32'(SEXT_M_TO_R));
  end

  // --------------------------------------------------------------------------
  // Stage 2: lightness times saturation
  // --------------------------------------------------------------------------
  logic [2*LW-1:0] s2_prod;
  logic [LW-1:0]   s2_sat, s2_lit;
  logic [FB-1:0]   s2_fract;
  sextant_t        s2_sext;
  logic            s2_grey;

  always_ff @(posedge clk) begin
    s2_prod  <= (2*LW)'(s1_sat) * (2*LW)'(s1_lit);
    s2_sat   <= s1_sat;
    s2_lit   <= s1_lit;
    s2_fract <= s1_fract;
    s2_sext  <= s1_sext;
    s2_grey  <= s1_grey;
  end

  // --------------------------------------------------------------------------
  // Stage 3: peak value v
  // --------------------------------------------------------------------------
  logic [LW-1:0] ls;
  logic [LW:0]   sum_lo, sum_hi, peak_raw;
  logic [LW-1:0] s3_peak, s3_lit;
  logic [FB-1:0] s3_fract;
  sextant_t      s3_sext;
  logic          s3_grey;

  assign ls       = LW'(s2_prod >> FB);
  assign sum_lo   = (LW+1)'(s2_lit) + (LW+1)'(ls);
  assign sum_hi   = (LW+1)'(s2_lit) + (LW+1)'(s2_sat) - (LW+1)'(ls);
  assign peak_raw = (s2_lit <= HALF) ? sum_lo : sum_hi;

  always_ff @(posedge clk) begin
    s3_peak  <= (peak_raw > (LW+1)'(ONE)) ? ONE : LW'(peak_raw);
    s3_lit   <= s2_lit;
    s3_fract <= s2_fract;
    s3_sext  <= s2_sext;
    s3_grey  <= s2_grey;
  end

  // --------------------------------------------------------------------------
  // Stage 4: raw floor 2l - v, limited below at zero
  // --------------------------------------------------------------------------
  logic [LW:0]   twol;
  logic [LW:0]   s4_floor_raw;
  logic [LW-1:0] s4_peak, s4_lit;
  logic [FB-1:0] s4_fract;
  sextant_t      s4_sext;
  logic          s4_grey;

  assign twol = {s3_lit, 1'b0};

  always_ff @(posedge clk) begin
    s4_floor_raw <= (twol > {1'b0, s3_peak}) ? (twol - {1'b0, s3_peak}) : '0;
    s4_peak      <= s3_peak;
    s4_lit       <= s3_lit;
    s4_fract     <= s3_fract;
    s4_sext      <= s3_sext;
    s4_grey      <= s3_grey | (s3_peak == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 5: floor limited to the peak, span v - m
  // --------------------------------------------------------------------------
  logic [LW-1:0] floor_lim;
  logic [LW-1:0] s5_floor, s5_span, s5_peak, s5_lit;
  logic [FB-1:0] s5_fract;
  sextant_t      s5_sext;
  logic          s5_grey;

  assign floor_lim = (s4_floor_raw > {1'b0, s4_peak}) ? s4_peak : LW'(s4_floor_raw);

  always_ff @(posedge clk) begin
    s5_floor <= floor_lim;
    s5_span  <= s4_peak - floor_lim;
    s5_peak  <= s4_peak;
    s5_lit   <= s4_lit;
    s5_fract <= s4_fract;
    s5_sext  <= s4_sext;
    s5_grey  <= s4_grey;
  end

  // --------------------------------------------------------------------------
  // Stage 6: span times hue fraction
  // --------------------------------------------------------------------------
  logic [LW+FB-1:0] s6_prod;
  logic [LW-1:0]    s6_floor, s6_peak, s6_lit;
  sextant_t         s6_sext;
  logic             s6_grey;

  always_ff @(posedge clk) begin
    s6_prod  <= (LW+FB)'(s5_span) * (LW+FB)'(s5_fract);
    s6_floor <= s5_floor;
    s6_peak  <= s5_peak;
    s6_lit   <= s5_lit;
    s6_sext  <= s5_sext;
    s6_grey  <= s5_grey;
  end

  // --------------------------------------------------------------------------
  // Stage 7: mid ramps and sextant select
  // --------------------------------------------------------------------------
  logic [LW-1:0] vsf, mid1, mid2;
  logic [LW-1:0] r_next, g_next, b_next;
  logic [LW-1:0] s7_r, s7_g, s7_b;

  assign vsf  = LW'(s6_prod >> FB);
  assign mid1 = s6_floor + vsf;
  assign mid2 = s6_peak - vsf;

  always_comb begin
    r_next = s6_lit;
    g_next = s6_lit;
    b_next = s6_lit;
    if (!s6_grey) begin
      case (s6_sext)
        SEXT_R_TO_Y: begin
          r_next = s6_peak;  g_next = mid1;     b_next = s6_floor;
        end
        SEXT_Y_TO_G: begin
          r_next = mid2;     g_next = s6_peak;  b_next = s6_floor;
        end
        SEXT_G_TO_C: begin
          r_next = s6_floor; g_next = s6_peak;  b_next = mid1;
        end
        SEXT_C_TO_B: begin
          r_next = s6_floor; g_next = mid2;     b_next = s6_peak;
        end
        SEXT_B_TO_M: begin
          r_next = mid1;     g_next = s6_floor; b_next = s6_peak;
        end
        SEXT_M_TO_R: begin
          r_next = s6_peak;  g_next = s6_floor; b_next = mid2;
        end
        default: begin
          r_next = s6_lit;   g_next = s6_lit;   b_next = s6_lit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s7_r <= r_next;
    s7_g <= g_next;
    s7_b <= b_next;
  end

  // --------------------------------------------------------------------------
  // Stage 8: scale to 8-bit channels, output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    red   <= to_chan(s7_r);
    green <= to_chan(s7_g);
    blue  <= to_chan(s7_b);
  end

  assign packed_color = {red, green, blue};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted transaction did not complete after LATENCY cycles");

  a_peak_limit: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> s3_peak <= ONE)
    else $error("peak value above 1.0");

  a_floor_order: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (s5_floor <= s5_peak) && (s5_span == s5_peak - s5_floor))
    else $error("floor above peak or span inconsistent");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    vld[6] && $past(s6_grey) |=> done && red == green && green == blue)
    else $error("grey transaction produced unequal channels");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for hsl_to_rgb_converter. A shared send task drives
// one HSL transaction at a time in random bursts. An input monitor predicts
// the RGB result of every accepted transaction and queues it. A checker
// compares each done strobe with the oldest queued prediction.
// ============================================================================
module tb_top;
  import hsl2rgb_pkg::*;

  localparam int FB = DEFAULT_FRACTION_BITS;
  localparam logic [63:0] ONE = 64'd1 << FB;
  localparam logic [63:0] HALF = ONE >> 1;
  localparam int LATENCY = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHANNEL_W-1:0] red;
    logic [CHANNEL_W-1:0] green;
    logic [CHANNEL_W-1:0] blue;
    logic [PACKED_W-1:0]  packed_color;
  } rgb_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [HUE_W-1:0]     hue = '0;
  logic [SL_W-1:0]      saturation = '0;
  logic [SL_W-1:0]      lightness = '0;
  logic                 done;
  logic [CHANNEL_W-1:0] red;
  logic [CHANNEL_W-1:0] green;
  logic [CHANNEL_W-1:0] blue;
  logic [PACKED_W-1:0]  packed_color;

  rgb_pixel_t pending_pixels[$];
  rgb_pixel_t want_pixel;
  int         sent_cnt = 0;
  int         checked_cnt = 0;
  int         error_cnt = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;

  hsl_to_rgb_converter #(
    .FRACTION_BITS(FB)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .hue          (hue),
    .saturation   (saturation),
    .lightness    (lightness),
    .done         (done),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .packed_color (packed_color)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Color predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] limit_to_one(input logic [63:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

  // Fraction to 8-bit channel, truncating
  function automatic logic [CHANNEL_W-1:0] scale_channel(input logic [63:0] x);
    logic [63:0] prod;
    prod = (limit_to_one(x) * 64'd255) >> FB;
    return prod[CHANNEL_W-1:0];
  endfunction

  function automatic rgb_pixel_t predict_rgb(input logic [HUE_W-1:0] h,
                                             input logic [SL_W-1:0]  s_in,
                                             input logic [SL_W-1:0]  l_in);
    logic [63:0] s, l, v, m, twol, h6, sextant, fract, span, mid1, mid2;
    logic [63:0] r, g, b;
    rgb_pixel_t  pix;
    s = limit_to_one(64'(s_in));
    l = limit_to_one(64'(l_in));
    r = l;
    g = l;
    b = l;
    // peak value
    if (l <= HALF) v = (l * (ONE + s)) >> FB;
    else v = l + s - ((l * s) >> FB);
    v = limit_to_one(v);
    // zero peak stays grey at the lightness level
    if (v > 0) begin
      twol = l + l;
      m = (twol > v) ? (twol - v) : 64'd0;
      if (m > v) m = v;
      h6 = 64'(h) * 64'd6;
      sextant = h6 >> FB;
      fract = h6 & (ONE - 64'd1);
      span = ((v - m) * fract) >> FB;
      mid1 = m + span;
      mid2 = v - span;
      // sextants past the last one keep grey
      if (sextant <= 64'd5) begin
        case (sextant_t'(sextant[2:0]))
          SEXT_R_TO_Y: begin r = v;    g = mid1; b = m;    end
          SEXT_Y_TO_G: begin r = mid2; g = v;    b = m;    end
          SEXT_G_TO_C: begin r = m;    g = v;    b = mid1; end
          SEXT_C_TO_B: begin r = m;    g = mid2; b = v;    end
          SEXT_B_TO_M: begin r = mid1; g = m;    b = v;    end
          SEXT_M_TO_R: begin r = v;    g = m;    b = mid2; end
          default: ;
        endcase
      end
    end
    pix.red = scale_channel(r);
    pix.green = scale_channel(g);
    pix.blue = scale_channel(b);
    pix.packed_color = {pix.red, pix.green, pix.blue};
    return pix;
  endfunction

  // --------------------------------------------------------------------------
  // Input monitor and result checker
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [PACKED_W-1:0] want,
                               input logic [PACKED_W-1:0] got);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%06h, got 0x%06h", $realtime, field,
               want, got);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // accepted transaction: queue its prediction
      if (start && !busy) pending_pixels.push_back(predict_rgb(hue, saturation, lightness));
      if (done) begin
        if (pending_pixels.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("[%0t] result 0x%06h with no transaction pending", $realtime,
                     packed_color);
        end else begin
          want_pixel = pending_pixels.pop_front();
          checked_cnt++;
          if (red !== want_pixel.red) note_mismatch("red", want_pixel.red, red);
          if (green !== want_pixel.green) note_mismatch("green", want_pixel.green, green);
          if (blue !== want_pixel.blue) note_mismatch("blue", want_pixel.blue, blue);
          if (packed_color !== want_pixel.packed_color)
            note_mismatch("packed_color", want_pixel.packed_color, packed_color);
        end
      end
    end
  end

  // Watchdog: too long with no transaction and no result
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One transaction; returns at the accepting edge
  task automatic send_hsl(input logic [HUE_W-1:0] h, input logic [SL_W-1:0] s,
                          input logic [SL_W-1:0] l);
    @(negedge clk);
    start <= 1'b1;
    hue <= h;
    saturation <= s;
    lightness <= l;
    do @(posedge clk); while (busy);
    sent_cnt++;
  endtask

  // Burst pacing: random burst lengths, random gaps (sometimes none)
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Level biased toward the interesting points around zero, half and one
  function automatic logic [SL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SL_W'(ONE);
      2: return SL_W'(HALF);
      3: return SL_W'(HALF) + SL_W'($urandom_range(0, 2)) - SL_W'(1);
      4: return SL_W'($urandom_range(0, 255));
      default: return SL_W'($urandom_range(0, 32'(ONE)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, grey cases, limiting above one, sextant edges
  task automatic test_corner_cases();
    send_hsl(16'h0000, 17'h00000, 17'h00000);   // black
    send_hsl(16'hFFFF, 17'h10000, 17'h10000);   // white
    send_hsl(16'h1234, 17'h00000, 17'h08000);   // no saturation: grey
    send_hsl(16'h4000, 17'h10000, 17'h00000);   // zero peak: grey at black
    send_hsl(16'h0000, 17'h10000, 17'h08000);   // pure red
    send_hsl(16'hFFFF, 17'h10000, 17'h08000);   // top of last sextant
    send_hsl(16'h5555, 17'h1FFFF, 17'h1FFFF);   // both above one: limited
    send_hsl(16'h2000, 17'h1FFFF, 17'h08000);   // saturation above one
    send_hsl(16'hA000, 17'h0C000, 17'h1FFFF);   // lightness above one
    send_hsl(16'h3000, 17'h10000, 17'h08001);   // just above half lightness
    send_hsl(16'h3000, 17'h10000, 17'h07FFF);   // just below half lightness
    send_hsl(16'h2AAA, 17'h10000, 17'h08000);   // sextant edges
    send_hsl(16'h2AAB, 17'h10000, 17'h08000);
    send_hsl(16'h5555, 17'h10000, 17'h08000);
    send_hsl(16'h5556, 17'h10000, 17'h08000);
    send_hsl(16'h8000, 17'h10000, 17'h08000);
    send_hsl(16'hAAAA, 17'h10000, 17'h08000);
    send_hsl(16'hAAAB, 17'h10000, 17'h08000);
    send_hsl(16'hD555, 17'h10000, 17'h08000);
    send_hsl(16'hD556, 17'h10000, 17'h08000);
    send_hsl(16'h7FFF, 17'h00001, 17'h00001);   // smallest nonzero levels
    send_hsl(16'h9999, 17'h0FFFF, 17'h0FFFF);   // just below one
  endtask

  // Hue swept through all six sextants with biased levels
  task automatic test_sextant_sweep(input int count);
    for (int k = 0; k < count; k++) begin
      pace_sender();
      send_hsl(HUE_W'(k * (65536 / count) + $urandom_range(0, 65536 / count - 1)),
               pick_level(), pick_level());
    end
  endtask

  // Levels in the legal range
  task automatic test_random_in_range(input int count);
    for (int k = 0; k < count; k++) begin
      pace_sender();
      send_hsl(HUE_W'($urandom), pick_level(), pick_level());
    end
  endtask

  // Every bit of every field, levels above one included
  task automatic test_random_full_range(input int count);
    for (int k = 0; k < count; k++) begin
      pace_sender();
      send_hsl(HUE_W'($urandom), SL_W'($urandom_range(0, 17'h1FFFF)),
               SL_W'($urandom_range(0, 17'h1FFFF)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_sextant_sweep(300);
    test_random_in_range(450);
    test_random_full_range(350);

    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_pixels.size() != 0) error_cnt++;

    $display("sent %0d transactions: corner cases, sextant sweep, random levels in and out of range",
             sent_cnt);
    $display("checked %0d results, %0d mismatches", checked_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
